>>> design/toroidal_neighborhood_addresser_macros.svh
// Assertion macros used by the checker file tna_checker.sv.
`ifndef TOROIDAL_NEIGHBORHOOD_ADDRESSER_MACROS_SVH
`define TOROIDAL_NEIGHBORHOOD_ADDRESSER_MACROS_SVH

// Concurrent check on clk, off while rst is high.
`define TNA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on clk that also holds while rst is high.
`define TNA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/tna_pkg.sv
package tna_pkg;

  // Default bound on the grid size
  localparam int TnaMaxDim = 1024;

  // Width of the grid size registers
  localparam int SizeW = 11;
  // Width of the APB address
  localparam int AddrW = 4;

  typedef enum logic [1:0] {
    SHAPE_L5  = 2'd0,
    SHAPE_L9  = 2'd1,
    SHAPE_C9  = 2'd2,
    SHAPE_C13 = 2'd3
  } shape_t;

  typedef enum logic [1:0] {
    REG_SHAPE = 2'd0,
    REG_ROWS  = 2'd1,
    REG_COLS  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [9:0] center_row;
    logic [9:0] center_col;
  } in_t;

  typedef struct packed {
    logic [9:0]  nbr_row;
    logic [9:0]  nbr_col;
    logic [19:0] nbr_index;
    logic        coord_error;
    logic        last_nbr;
  } out_t;

  // Offsets packed as {row + 2, col + 2}, one octal digit each
  localparam logic [5:0] TabL5 [13] = '{
    6'o22, 6'o21, 6'o12, 6'o23, 6'o32,
    6'o22, 6'o22, 6'o22, 6'o22, 6'o22, 6'o22, 6'o22, 6'o22
  };
  localparam logic [5:0] TabL9 [13] = '{
    6'o22, 6'o21, 6'o20, 6'o12, 6'o02, 6'o23, 6'o24, 6'o32, 6'o42,
    6'o22, 6'o22, 6'o22, 6'o22
  };
  localparam logic [5:0] TabC13 [13] = '{
    6'o11, 6'o12, 6'o13, 6'o21, 6'o22, 6'o23, 6'o31, 6'o32, 6'o33,
    6'o20, 6'o02, 6'o24, 6'o42
  };

  // Offset pair of step k for the given shape
  function automatic logic [5:0] nbr_offset(shape_t shape, logic [3:0] k);
    logic [5:0] off;
    unique case (shape)
      SHAPE_L5: off = TabL5[k];
      SHAPE_L9: off = TabL9[k];
      default:  off = TabC13[k];
    endcase
    return off;
  endfunction

  // Number of neighbors in the given shape
  function automatic logic [3:0] shape_count(shape_t shape);
    logic [3:0] n;
    unique case (shape)
      SHAPE_L5:  n = 4'd5;
      SHAPE_L9:  n = 4'd9;
      SHAPE_C9:  n = 4'd9;
      default:   n = 4'd13;
    endcase
    return n;
  endfunction

endpackage

>>> design/toroidal_neighborhood_addresser.sv
// The input transfer loads the item register; each step is registered in the
// wrap stage, then in the output register. Throughput: one result per cycle
// unless out_ready stalls; the single address step unit runs 5 (L5), 9 (L9, C9)
// or 13 (C13) steps per item, 1 if out of grid. The next item is taken in the
// cycle the previous item's last step issues. Reset (rst, synchronous): drops
// all pending work, shape_mode = L5, grid_rows and grid_cols = low 11 bits of MAX_DIM.
module toroidal_neighborhood_addresser
  import tna_pkg::*;
#(
  parameter int MAX_DIM = TnaMaxDim
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [12:0] MaxDimW = 13'(MAX_DIM);

  shape_t           shape_mode;
  logic [SizeW-1:0] grid_rows;
  logic [SizeW-1:0] grid_cols;
  logic [SizeW-1:0] rows_eff;
  logic [SizeW-1:0] cols_eff;
  reg_idx_t         reg_idx;

  logic             busy;
  in_t              item;
  logic [3:0]       k;
  logic             item_err;
  logic             step_last;
  logic             emit;
  logic [5:0]       off;

  logic             s1_valid;
  logic [SizeW-1:0] s1_row;
  logic [SizeW-1:0] s1_col;
  logic             s1_err;
  logic             s1_last;
  logic             s1_ready;
  logic             o_ready;
  logic [2*SizeW-1:0] prod;

  // Wrap c + (d2 - 2) onto 0..n-1
  function automatic logic [SizeW-1:0] wrap(logic [9:0] c, logic [2:0] d2,
                                             logic [SizeW-1:0] n);
    logic [12:0] t;
    t = 13'(c) + 13'(d2) + {1'b0, n, 1'b0} - 13'd2;
    for (int i = 0; i < 4; i++) begin
      if (t >= {2'b00, n}) begin
        t = t - {2'b00, n};
      end
    end
    return t[SizeW-1:0];
  endfunction

  // Clamp a size register to 1..MAX_DIM
  function automatic logic [SizeW-1:0] eff_size(logic [SizeW-1:0] v);
    logic [SizeW-1:0] e;
    priority if (v == '0) begin
      e = SizeW'(1);
    end else if ({2'b00, v} > MaxDimW) begin
      e = MaxDimW[SizeW-1:0];
    end else begin
      e = v;
    end
    return e;
  endfunction

  assign reg_idx  = reg_idx_t'(paddr[3:2]);
  assign pready   = 1'b1;
  assign rows_eff = eff_size(grid_rows);
  assign cols_eff = eff_size(grid_cols);

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode <= SHAPE_L5;
      grid_rows  <= SizeW'(MAX_DIM);
      grid_cols  <= SizeW'(MAX_DIM);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_SHAPE: shape_mode <= shape_t'(pwdata[1:0]);
        REG_ROWS:  grid_rows  <= pwdata[SizeW-1:0];
        REG_COLS:  grid_cols  <= pwdata[SizeW-1:0];
        default:   ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_SHAPE: prdata = {30'd0, shape_mode};
      REG_ROWS:  prdata = {{(32-SizeW){1'b0}}, grid_rows};
      REG_COLS:  prdata = {{(32-SizeW){1'b0}}, grid_cols};
      default:   prdata = '0;
    endcase
  end

  // Stall chain from the output register back to the step unit
  assign o_ready   = !out_valid || out_ready;
  assign s1_ready  = !s1_valid || o_ready;
  assign emit      = busy && s1_ready;
  assign item_err  = ({1'b0, item.center_row} >= rows_eff) ||
                     ({1'b0, item.center_col} >= cols_eff);
  assign step_last = item_err || (k == shape_count(shape_mode) - 4'd1);
  assign in_ready  = !busy || (emit && step_last);
  assign off       = nbr_offset(shape_mode, k);

  // Hold the current item and advance through its neighbor list
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      k    <= '0;
    end else if (emit && step_last) begin
      busy <= 1'b0;
    end else if (emit) begin
      k <= k + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  // Wrap stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_err  <= item_err;
      s1_last <= step_last;
      if (item_err) begin
        s1_row <= '0;
        s1_col <= '0;
      end else begin
        s1_row <= wrap(item.center_row, off[5:3], rows_eff);
        s1_col <= wrap(item.center_col, off[2:0], cols_eff);
      end
    end
  end

  // Linear index and output register
  assign prod = s1_row * cols_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && s1_valid) begin
      out_data.nbr_row     <= s1_row[9:0];
      out_data.nbr_col     <= s1_col[9:0];
      out_data.nbr_index   <= prod[19:0] + 20'(s1_col);
      out_data.coord_error <= s1_err;
      out_data.last_nbr    <= s1_last;
    end
  end

endmodule

>>> design/tna_checker.sv
`include "toroidal_neighborhood_addresser_macros.svh"

module tna_checker
  import tna_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data,
  input logic pready
);

  // Hold a stalled result
  `TNA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // Out-of-grid result is a single, zeroed, final transfer
  `TNA_ASSERT(a_err_result, out_valid && out_data.coord_error |-> out_data.last_nbr && out_data.nbr_row == 10'd0 && out_data.nbr_col == 10'd0 && out_data.nbr_index == 20'd0, "bad out-of-grid result")

  // Nothing is shown right after reset
  `TNA_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "result valid after reset")

  // Idle block after reset takes an input
  `TNA_ASSERT_ALWAYS(a_ready_after_reset, rst |=> in_ready, "input not ready after reset")

  // Config port never waits
  `TNA_ASSERT(a_pready, pready, "pready low")

endmodule

bind toroidal_neighborhood_addresser tna_checker u_tna_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
